// ===== hw/rtl/tpa_pkg.sv =====
// Shared constants, types and square-root step functions for the triangle perimeter/area block.
package tpa_pkg;

   localparam int COORD_BITS = 12;
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int SQ_W       = 2 * COORD_BITS;
   localparam int D2_W       = 2 * COORD_BITS + 1;
   localparam int FRAC_SHIFT = 16;
   localparam int SIDE_W     = (D2_W + FRAC_SHIFT + 1) / 2;
   localparam int SIDE_RAD_W = 2 * SIDE_W;
   localparam int SIDE_REM_W = SIDE_W + 1;
   localparam int S_W        = SIDE_W + 2;
   localparam int M_W        = 2 * S_W;
   localparam int PROD_W     = 4 * S_W;
   localparam int AREA_W     = 2 * S_W;
   localparam int AREA_REM_W = AREA_W + 1;
   localparam int AREA_DROP  = 10;
   localparam int PERIM_W    = 22;
   localparam int AREA_OUT_W = 31;
   localparam logic [63:0] PERIM_MAX = 64'd4194303;
   localparam logic [63:0] AREA_MAX  = 64'd2147483647;

   // input reg, diff, square sum, side roots, sum, factors, muls,
   // partial products, middle sum, product, area root, output reg
   localparam int LAT = 3 + SIDE_W + 6 + AREA_W + 1;

   typedef struct packed {
      logic [SIDE_REM_W-1:0] rem;
      logic [SIDE_W-1:0]     root;
   } side_step_type;

   typedef struct packed {
      logic [AREA_REM_W-1:0] rem;
      logic [AREA_W-1:0]     root;
   } area_step_type;

   function automatic side_step_type side_step(input logic [SIDE_REM_W-1:0] rem,
                                               input logic [SIDE_W-1:0] root,
                                               input logic [1:0] dig);
      logic [SIDE_REM_W+1:0] wide;
      logic [SIDE_REM_W+1:0] trial;
      side_step_type         res;
      wide  = {rem, dig};
      trial = (SIDE_REM_W + 2)'({root, 2'b01});
      if (wide >= trial) begin
         res.rem  = SIDE_REM_W'(wide - trial);
         res.root = {root[SIDE_W-2:0], 1'b1};
      end else begin
         res.rem  = SIDE_REM_W'(wide);
         res.root = {root[SIDE_W-2:0], 1'b0};
      end
      return res;
   endfunction

   function automatic area_step_type area_step(input logic [AREA_REM_W-1:0] rem,
                                               input logic [AREA_W-1:0] root,
                                               input logic [1:0] dig);
      logic [AREA_REM_W+1:0] wide;
      logic [AREA_REM_W+1:0] trial;
      area_step_type         res;
      wide  = {rem, dig};
      trial = (AREA_REM_W + 2)'({root, 2'b01});
      if (wide >= trial) begin
         res.rem  = AREA_REM_W'(wide - trial);
         res.root = {root[AREA_W-2:0], 1'b1};
      end else begin
         res.rem  = AREA_REM_W'(wide);
         res.root = {root[AREA_W-2:0], 1'b0};
      end
      return res;
   endfunction

endpackage

// ===== hw/rtl/triangle_perimeter_area_top.sv =====
// Top level of the triangle perimeter and Heron area pipeline.
//
// Takes one triangle per cycle unless stalled and returns its perimeter and area
// through 1 input register, 2 difference/square stages, 21 side square-root
// stages, 6 sum/factor/multiply stages, 46 area square-root stages and 1 output
// register. The whole pipeline holds while a result waits under rsp_stall;
// req_stall follows rsp_stall only when the output register is occupied.
module triangle_perimeter_area_top import tpa_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_ax,
   input  logic signed [COORD_BITS-1:0] req_ay,
   input  logic signed [COORD_BITS-1:0] req_bx,
   input  logic signed [COORD_BITS-1:0] req_by_coord,
   input  logic signed [COORD_BITS-1:0] req_cx,
   input  logic signed [COORD_BITS-1:0] req_cy,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [PERIM_W-1:0]           rsp_perimeter_len,
   output logic [AREA_OUT_W-1:0]        rsp_area_val
);

   logic adv;
   logic vld_ff [LAT];

   logic signed [COORD_BITS-1:0] ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff;
   logic signed [DIFF_W-1:0]     dx_ff [3];
   logic signed [DIFF_W-1:0]     dy_ff [3];
   logic [D2_W-1:0]              d2_ff [3];
   logic [SIDE_W-1:0]            side  [3];
   logic [SIDE_W-1:0]            side_ff [3];
   logic [S_W-1:0]               s_ff, f_s_ff, m_s_ff, pp_s_ff, mid_s_ff, prod_s_ff;
   logic [S_W-1:0]               fac_ff [3];
   logic [M_W-1:0]               m1_ff, m2_ff;
   logic [M_W-1:0]               pp00_ff, pp01_ff, pp10_ff, pp11_ff;
   logic [M_W-1:0]               lo_ff, hi_ff;
   logic [M_W:0]                 mid_ff;
   logic [PROD_W-1:0]            prod_ff;
   logic [S_W-1:0]               s_line_ff [AREA_W];
   logic [AREA_W-1:0]            root;
   logic [AREA_W-AREA_DROP-1:0]  area_full;
   logic [PERIM_W-1:0]           perim_ff;
   logic [AREA_OUT_W-1:0]        area_ff;

   assign adv       = !(vld_ff[LAT-1] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) vld_ff[i] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // sides: AB, AC, CB
   always_ff @(posedge clock) begin
      if (adv) begin
         ax_ff <= req_ax;
         ay_ff <= req_ay;
         bx_ff <= req_bx;
         by_ff <= req_by_coord;
         cx_ff <= req_cx;
         cy_ff <= req_cy;
         dx_ff[0] <= DIFF_W'(ax_ff) - DIFF_W'(bx_ff);
         dy_ff[0] <= DIFF_W'(ay_ff) - DIFF_W'(by_ff);
         dx_ff[1] <= DIFF_W'(ax_ff) - DIFF_W'(cx_ff);
         dy_ff[1] <= DIFF_W'(ay_ff) - DIFF_W'(cy_ff);
         dx_ff[2] <= DIFF_W'(cx_ff) - DIFF_W'(bx_ff);
         dy_ff[2] <= DIFF_W'(cy_ff) - DIFF_W'(by_ff);
         for (int i = 0; i < 3; i++) begin
            d2_ff[i] <= {1'b0, SQ_W'(dx_ff[i] * dx_ff[i])}
                      + {1'b0, SQ_W'(dy_ff[i] * dy_ff[i])};
         end
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_side
      tpa_side_root u_side_root (
         .clock (clock),
         .adv   (adv),
         .d2    (d2_ff[i]),
         .side  (side[i])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) side_ff[i] <= side[i];
         s_ff <= S_W'(side[0]) + S_W'(side[1]) + S_W'(side[2]);
         f_s_ff <= s_ff;
         for (int i = 0; i < 3; i++) begin
            if (s_ff > {1'b0, side_ff[i], 1'b0}) begin
               fac_ff[i] <= s_ff - {1'b0, side_ff[i], 1'b0};
            end else begin
               fac_ff[i] <= '0;
            end
         end
         m_s_ff <= f_s_ff;
         m1_ff  <= M_W'(f_s_ff) * M_W'(fac_ff[0]);
         m2_ff  <= M_W'(fac_ff[1]) * M_W'(fac_ff[2]);
         pp_s_ff <= m_s_ff;
         pp00_ff <= M_W'(m1_ff[S_W-1:0]) * M_W'(m2_ff[S_W-1:0]);
         pp01_ff <= M_W'(m1_ff[S_W-1:0]) * M_W'(m2_ff[M_W-1:S_W]);
         pp10_ff <= M_W'(m1_ff[M_W-1:S_W]) * M_W'(m2_ff[S_W-1:0]);
         pp11_ff <= M_W'(m1_ff[M_W-1:S_W]) * M_W'(m2_ff[M_W-1:S_W]);
         mid_s_ff <= pp_s_ff;
         lo_ff    <= pp00_ff;
         hi_ff    <= pp11_ff;
         mid_ff   <= (M_W + 1)'(pp01_ff) + (M_W + 1)'(pp10_ff);
         prod_s_ff <= mid_s_ff;
         prod_ff   <= {hi_ff, lo_ff} + PROD_W'({mid_ff, {S_W{1'b0}}});
         s_line_ff[0] <= prod_s_ff;
         for (int i = 1; i < AREA_W; i++) s_line_ff[i] <= s_line_ff[i-1];
      end
   end

   tpa_area_root u_area_root (
      .clock (clock),
      .adv   (adv),
      .prod  (prod_ff),
      .root  (root)
   );

   assign area_full = root[AREA_W-1:AREA_DROP];

   always_ff @(posedge clock) begin
      if (adv) begin
         if (64'(s_line_ff[AREA_W-1]) > PERIM_MAX) begin
            perim_ff <= PERIM_W'(PERIM_MAX);
         end else begin
            perim_ff <= PERIM_W'(s_line_ff[AREA_W-1]);
         end
         if (64'(area_full) > AREA_MAX) begin
            area_ff <= AREA_OUT_W'(AREA_MAX);
         end else begin
            area_ff <= AREA_OUT_W'(area_full);
         end
      end
   end

   assign rsp_perimeter_len = perim_ff;
   assign rsp_area_val      = area_ff;

endmodule

// ===== hw/rtl/tpa_side_root.sv =====
// Pipelined integer square root of a squared side length, one result bit per stage.
module tpa_side_root import tpa_pkg::*; (
   input  logic              clock,
   input  logic              adv,
   input  logic [D2_W-1:0]   d2,
   output logic [SIDE_W-1:0] side
);

   logic [SIDE_REM_W-1:0] rem_ff  [SIDE_W];
   logic [SIDE_W-1:0]     root_ff [SIDE_W];
   logic [SIDE_RAD_W-1:0] rad_ff  [SIDE_W];

   for (genvar k = 0; k < SIDE_W; k++) begin : g_stage
      logic [SIDE_REM_W-1:0] rem_src;
      logic [SIDE_W-1:0]     root_src;
      logic [SIDE_RAD_W-1:0] rad_src;
      side_step_type         step_in;

      if (k == 0) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = SIDE_RAD_W'({d2, {FRAC_SHIFT{1'b0}}});
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign rad_src  = rad_ff[k-1];
      end

      assign step_in = side_step(rem_src, root_src, rad_src[SIDE_RAD_W-1 -: 2]);

      always_ff @(posedge clock) begin
         if (adv) begin
            root_ff[k] <= step_in.root;
            rem_ff[k]  <= step_in.rem;
            rad_ff[k]  <= rad_src << 2;
         end
      end
   end

   assign side = root_ff[SIDE_W-1];

endmodule

// ===== hw/rtl/tpa_area_root.sv =====
// Pipelined integer square root of the Heron product, one result bit per stage.
module tpa_area_root import tpa_pkg::*; (
   input  logic              clock,
   input  logic              adv,
   input  logic [PROD_W-1:0] prod,
   output logic [AREA_W-1:0] root
);

   logic [AREA_REM_W-1:0] rem_ff  [AREA_W];
   logic [AREA_W-1:0]     root_ff [AREA_W];
   logic [PROD_W-1:0]     rad_ff  [AREA_W];

   for (genvar k = 0; k < AREA_W; k++) begin : g_stage
      logic [AREA_REM_W-1:0] rem_src;
      logic [AREA_W-1:0]     root_src;
      logic [PROD_W-1:0]     rad_src;
      area_step_type         step_in;

      if (k == 0) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = prod;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign rad_src  = rad_ff[k-1];
      end

      assign step_in = area_step(rem_src, root_src, rad_src[PROD_W-1 -: 2]);

      always_ff @(posedge clock) begin
         if (adv) begin
            root_ff[k] <= step_in.root;
            rem_ff[k]  <= step_in.rem;
            rad_ff[k]  <= rad_src << 2;
         end
      end
   end

   assign root = root_ff[AREA_W-1];

endmodule

// ===== hw/rtl/tpa_checker.sv =====
// Port-level checker for the triangle perimeter/area block, with its bind.
module tpa_checker import tpa_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [PERIM_W-1:0]    rsp_perimeter_len,
   input logic [AREA_OUT_W-1:0] rsp_area_val
);

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a waiting transaction");

   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled while output empty");

   a_zero_perim_zero_area: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_perimeter_len == '0) |-> (rsp_area_val == '0))
      else $error("nonzero area with zero perimeter");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_perimeter_len)
                                    && $stable(rsp_area_val)))
      else $error("stalled response changed");

endmodule

bind triangle_perimeter_area_top tpa_checker u_tpa_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_perimeter_len (rsp_perimeter_len),
   .rsp_area_val      (rsp_area_val)
);
